>>> rtl/keypad_two_operand_calculator_top_macros.svh
// ----------------------------------------------------------------------------
// keypad_two_operand_calculator_top_macros: assertion helpers
// Same-cycle and next-cycle implication checks on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_TWO_OPERAND_CALCULATOR_TOP_MACROS_SVH
`define KEYPAD_TWO_OPERAND_CALCULATOR_TOP_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define KPC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kpc check failed");

// antecedent holds -> consequent holds in the next cycle
`define KPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kpc check failed");

`endif

>>> rtl/kpc_pkg.sv
// ----------------------------------------------------------------------------
// kpc_pkg: shared types and constants of the keypad calculator
// Key codes, operation codes, arithmetic unit states and handoff structs.
// ----------------------------------------------------------------------------
package kpc_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int MAX_DIGITS  = 9;
  localparam int KEY_W       = 8;
  localparam int RESULT_W    = 32;
  localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int ITER_CNT_W  = $clog2(VALUE_BITS);

  localparam logic [KEY_W-1:0] KEY_EQ   = 8'h3D;
  localparam logic [KEY_W-1:0] KEY_MUL  = 8'h2A;
  localparam logic [KEY_W-1:0] KEY_DIV  = 8'h2F;
  localparam logic [KEY_W-1:0] KEY_ADD  = 8'h2B;
  localparam logic [KEY_W-1:0] KEY_SUB  = 8'h2D;
  localparam logic [KEY_W-1:0] KEY_ZERO = 8'h30;
  localparam logic [KEY_W-1:0] KEY_NINE = 8'h39;

  typedef enum logic [1:0] {
    OP_SUB = 2'd0,
    OP_MUL = 2'd1,
    OP_DIV = 2'd2,
    OP_ADD = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ALU_IDLE,
    ALU_MUL,
    ALU_DIV,
    ALU_FIX,
    ALU_DONE
  } alu_state_e;

  typedef struct packed {
    logic                  start;
    op_e                   op;
    logic [VALUE_BITS-1:0] opa;
    logic [VALUE_BITS-1:0] opb;
  } kpc_start_t;

  typedef struct packed {
    logic idle;
    logic done;
  } kpc_status_t;

  // sign-extend or wrap an operand-width value to the result width
  function automatic logic [RESULT_W-1:0] to_result(input logic [VALUE_BITS-1:0] v);
    logic signed [VALUE_BITS-1:0] s;
    s = v;
    return RESULT_W'(s);
  endfunction

endpackage

>>> rtl/kpc_entry.sv
// ----------------------------------------------------------------------------
// kpc_entry: key decoder and operand entry
// Builds the two decimal operands, tracks the operator and entry phase, and
// issues a start to the arithmetic unit on a result key.
// ----------------------------------------------------------------------------
module kpc_entry
  import kpc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [KEY_W-1:0] key_i,
  output kpc_start_t       start_o
);

  logic [VALUE_BITS-1:0]  first_q, first_d;
  logic [VALUE_BITS-1:0]  second_q, second_d;
  logic                   first_stop_q, first_stop_d;
  logic                   second_stop_q, second_stop_d;
  logic [DIGIT_CNT_W-1:0] first_cnt_q, first_cnt_d;
  logic [DIGIT_CNT_W-1:0] second_cnt_q, second_cnt_d;
  op_e                    op_q, op_d;
  logic [1:0]             phase_q, phase_d;

  logic                   is_digit;
  logic                   is_op;
  logic                   compute;
  logic [3:0]             digit;
  logic [VALUE_BITS-1:0]  first_next;
  logic [VALUE_BITS-1:0]  second_next;

  assign is_digit = (key_i >= KEY_ZERO) && (key_i <= KEY_NINE);
  assign is_op    = (key_i == KEY_MUL) || (key_i == KEY_DIV) ||
                    (key_i == KEY_ADD) || (key_i == KEY_SUB);
  // phase two (or the unused three) turns any key into a result key
  assign compute  = (key_i == KEY_EQ) || phase_q[1];
  assign digit    = 4'(key_i - KEY_ZERO);

  // value * 10 + digit
  assign first_next  = (first_q << 3) + (first_q << 1) + VALUE_BITS'(digit);
  assign second_next = (second_q << 3) + (second_q << 1) + VALUE_BITS'(digit);

  always_comb begin
    first_d       = first_q;
    second_d      = second_q;
    first_stop_d  = first_stop_q;
    second_stop_d = second_stop_q;
    first_cnt_d   = first_cnt_q;
    second_cnt_d  = second_cnt_q;
    op_d          = op_q;
    phase_d       = phase_q;
    if (accept_i) begin
      if (compute) begin
        first_d       = '0;
        second_d      = '0;
        first_stop_d  = 1'b0;
        second_stop_d = 1'b0;
        first_cnt_d   = '0;
        second_cnt_d  = '0;
        phase_d       = '0;
      end else if (is_op) begin
        case (key_i)
          KEY_MUL: op_d = OP_MUL;
          KEY_DIV: op_d = OP_DIV;
          KEY_ADD: op_d = OP_ADD;
          default: op_d = OP_SUB;
        endcase
        phase_d = phase_q + 2'd1;
      end else if (phase_q == 2'd0) begin
        if (!is_digit) begin
          first_stop_d = 1'b1;
        end else if (!first_stop_q && (first_cnt_q < DIGIT_CNT_W'(MAX_DIGITS))) begin
          first_d     = first_next;
          first_cnt_d = first_cnt_q + DIGIT_CNT_W'(1);
        end
      end else begin
        if (!is_digit) begin
          second_stop_d = 1'b1;
        end else if (!second_stop_q && (second_cnt_q < DIGIT_CNT_W'(MAX_DIGITS))) begin
          second_d     = second_next;
          second_cnt_d = second_cnt_q + DIGIT_CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q       <= '0;
      second_q      <= '0;
      first_stop_q  <= 1'b0;
      second_stop_q <= 1'b0;
      first_cnt_q   <= '0;
      second_cnt_q  <= '0;
      op_q          <= OP_SUB;
      phase_q       <= '0;
    end else begin
      first_q       <= first_d;
      second_q      <= second_d;
      first_stop_q  <= first_stop_d;
      second_stop_q <= second_stop_d;
      first_cnt_q   <= first_cnt_d;
      second_cnt_q  <= second_cnt_d;
      op_q          <= op_d;
      phase_q       <= phase_d;
    end
  end

  assign start_o.start = accept_i && compute;
  assign start_o.op    = op_q;
  assign start_o.opa   = first_q;
  assign start_o.opb   = second_q;

endmodule

>>> rtl/kpc_alu.sv
// ----------------------------------------------------------------------------
// kpc_alu: iterative arithmetic unit
// Add and subtract in one step; multiply by shift-add and divide by
// restoring division, one operand bit per cycle. Holds the result until ack.
// ----------------------------------------------------------------------------
module kpc_alu
  import kpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kpc_start_t            start_i,
  input  logic                  ack_i,
  output kpc_status_t           status_o,
  output logic [VALUE_BITS-1:0] result_o,
  output logic                  div_zero_o
);

  alu_state_e state_q, state_d;

  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [VALUE_BITS-1:0] opa_q, opa_d;
  logic [VALUE_BITS-1:0] opb_q, opb_d;
  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic [ITER_CNT_W-1:0] cnt_q, cnt_d;
  logic                  neg_q, neg_d;
  logic                  dz_q, dz_d;

  logic                  a_neg;
  logic                  b_neg;
  logic                  b_zero;
  logic [VALUE_BITS:0]   trial;

  assign a_neg  = start_i.opa[VALUE_BITS-1];
  assign b_neg  = start_i.opb[VALUE_BITS-1];
  assign b_zero = (start_i.opb == '0);
  assign trial  = {rem_q, opa_q[VALUE_BITS-1]} - {1'b0, opb_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ALU_IDLE: begin
        if (start_i.start) begin
          case (start_i.op)
            OP_MUL:  state_d = ALU_MUL;
            OP_DIV:  state_d = b_zero ? ALU_DONE : ALU_DIV;
            default: state_d = ALU_DONE;
          endcase
        end
      end
      ALU_MUL: if (cnt_q == '0) state_d = ALU_DONE;
      ALU_DIV: if (cnt_q == '0) state_d = ALU_FIX;
      ALU_FIX: state_d = ALU_DONE;
      ALU_DONE: if (ack_i) state_d = ALU_IDLE;
      default: state_d = ALU_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    status_o.idle = (state_q == ALU_IDLE);
    status_o.done = (state_q == ALU_DONE);
  end

  assign result_o   = acc_q;
  assign div_zero_o = dz_q;

  // datapath
  always_comb begin
    acc_d = acc_q;
    opa_d = opa_q;
    opb_d = opb_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    dz_d  = dz_q;
    case (state_q)
      ALU_IDLE: begin
        cnt_d = ITER_CNT_W'(VALUE_BITS - 1);
        rem_d = '0;
        neg_d = a_neg ^ b_neg;
        dz_d  = 1'b0;
        opa_d = start_i.opa;
        opb_d = start_i.opb;
        case (start_i.op)
          OP_ADD: acc_d = start_i.opa + start_i.opb;
          OP_SUB: acc_d = start_i.opa - start_i.opb;
          OP_DIV: begin
            acc_d = '0;
            dz_d  = b_zero;
            // magnitudes; the most negative value maps onto itself, read unsigned
            if (a_neg) opa_d = '0 - start_i.opa;
            if (b_neg) opb_d = '0 - start_i.opb;
          end
          default: acc_d = '0;
        endcase
      end
      ALU_MUL: begin
        if (opb_q[0]) acc_d = acc_q + opa_q;
        opa_d = opa_q << 1;
        opb_d = opb_q >> 1;
        cnt_d = cnt_q - ITER_CNT_W'(1);
      end
      ALU_DIV: begin
        // quotient bits shift into opa as the dividend shifts out
        if (!trial[VALUE_BITS]) begin
          rem_d = trial[VALUE_BITS-1:0];
        end else begin
          rem_d = {rem_q[VALUE_BITS-2:0], opa_q[VALUE_BITS-1]};
        end
        opa_d = {opa_q[VALUE_BITS-2:0], ~trial[VALUE_BITS]};
        cnt_d = cnt_q - ITER_CNT_W'(1);
      end
      ALU_FIX: acc_d = neg_q ? ('0 - opa_q) : opa_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ALU_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    opa_q <= opa_d;
    opb_q <= opb_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
    dz_q  <= dz_d;
  end

endmodule

>>> rtl/keypad_two_operand_calculator_top.sv
// ----------------------------------------------------------------------------
// keypad_two_operand_calculator_top: four-function keypad calculator
// Results: digit/operator keys give none; a result key's transfer starts the arithmetic unit.
//   Add, subtract, divide by zero go straight to done; multiply and divide run their loop first.
// Throughput: one key per cycle while idle; a result key holds off input until the unit is done
//   (for multiply and divide, after the shift-add / restoring-divide loop) and the output register takes the result.
// Reset: async active low; operands, digit counts, phase cleared, operation set to subtract.
// ----------------------------------------------------------------------------
module keypad_two_operand_calculator_top
  import kpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [KEY_W-1:0]    s_axis_tdata,   // [7:0] key_code
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [RESULT_W-1:0] m_axis_tdata,   // [31:0] result_value
  output logic                m_axis_tuser    // [0] divide_by_zero
);

  kpc_start_t            start;
  kpc_status_t           status;
  logic [VALUE_BITS-1:0] alu_result;
  logic                  alu_dz;
  logic                  accept;
  logic                  load;

  logic                  out_valid_q, out_valid_d;
  logic [RESULT_W-1:0]   out_data_q;
  logic                  out_dz_q;

  assign s_axis_tready = status.idle;
  assign accept        = s_axis_tvalid && s_axis_tready;
  // result register takes the unit's result when empty or draining
  assign load          = status.done && (!out_valid_q || m_axis_tready);

  kpc_entry u_entry (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .key_i    (s_axis_tdata),
    .start_o  (start)
  );

  kpc_alu u_alu (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .ack_i      (load),
    .status_o   (status),
    .result_o   (alu_result),
    .div_zero_o (alu_dz)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= to_result(alu_result);
      out_dz_q   <= alu_dz;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_dz_q;

endmodule

>>> rtl/kpc_checker.sv
// ----------------------------------------------------------------------------
// kpc_checker: port-level checks of the keypad calculator
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
`include "keypad_two_operand_calculator_top_macros.svh"

module kpc_prop_checker
  import kpc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [KEY_W-1:0]    s_axis_tdata,   // [7:0] key_code
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [RESULT_W-1:0] m_axis_tdata,   // [31:0] result_value
  input logic                m_axis_tuser    // [0] divide_by_zero
);

  // stalled result stays up and unchanged
  `KPC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `KPC_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

  // an equals key starts a calculation, so input is held off next cycle
  `KPC_ASSERT_NEXT(a_eq_busy, s_axis_tvalid && s_axis_tready && (s_axis_tdata == KEY_EQ),
                   !s_axis_tready)

  // a zero divisor always reports a zero result
  `KPC_ASSERT_SAME(a_dz_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)

endmodule

bind keypad_two_operand_calculator_top kpc_prop_checker u_kpc_checker (.*);
